// ===== rtl/lpbrq_pkg.sv =====
// Package with the item types, codes and sizes shared by the ring queue modules.
package lpbrq_pkg;

  localparam int BUFFER_BYTES_DEF = 1024;
  localparam int MAX_ENTRY_DEF    = 64;
  localparam int HEADER_BYTES     = 2;
  localparam int CMD_QUEUE_DEPTH  = 2;
  localparam int RES_QUEUE_DEPTH  = 2;

  localparam logic MODE_WRITE = 1'b0;
  localparam logic MODE_READ  = 1'b1;

  typedef enum logic [2:0] {
    ST_READ_BYTE      = 3'd0,
    ST_SKIPPED        = 3'd1,
    ST_EMPTY          = 3'd2,
    ST_WRITE_ACCEPTED = 3'd3,
    ST_WRITE_REJECTED = 3'd4
  } status_e;

  typedef enum logic [1:0] {
    OP_WR_START,
    OP_WR_BYTE,
    OP_WR_ZERO,
    OP_READ
  } cmd_op_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_WHDR,
    S_WDATA,
    S_RLEN,
    S_RDATA,
    S_PUSH
  } back_state_e;

  typedef struct packed {
    logic       mode;
    logic [5:0] entry_length;
    logic [7:0] in_byte;
    logic [6:0] read_limit;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    status_e    status;
    logic [5:0] read_count;
    logic       last;
  } result_t;

  typedef struct packed {
    cmd_op_e    op;
    logic       last;
    logic [5:0] len;
    logic [7:0] data;
    logic [6:0] read_limit;
  } cmd_t;

endpackage

// ===== rtl/lpbrq_fifo.sv =====
// Small register queue used between the front and back parts and at the result side.
module lpbrq_fifo #(
  parameter int Width = 8,
  parameter int Depth = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             pop_i,
  output logic [Width-1:0] rdata_o,
  output logic             full_o,
  output logic             empty_o
);

  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW = $clog2(Depth + 1);

  logic [Width-1:0] mem_q [Depth];
  logic [PtrW-1:0]  wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]  rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic             do_push;
  logic             do_pop;

  assign full_o  = (cnt_q == CntW'(Depth));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign rdata_o = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= wdata_i;
    end
  end

endmodule

// ===== rtl/lpbrq_front.sv =====
// Front part that accepts items and classifies write bytes by their place in an entry.
module lpbrq_front import lpbrq_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     item_push_i,
  input  in_item_t item_i,
  input  logic     cmd_full_i,
  output logic     cmd_push_o,
  output cmd_t     cmd_o
);

  logic [5:0] rem_q, rem_d;
  logic       accept;

  assign accept     = item_push_i && !cmd_full_i;
  assign cmd_push_o = accept;

  always_comb begin
    rem_d            = rem_q;
    cmd_o.op         = OP_READ;
    cmd_o.last       = 1'b1;
    cmd_o.len        = item_i.entry_length;
    cmd_o.data       = item_i.in_byte;
    cmd_o.read_limit = item_i.read_limit;
    if (item_i.mode == MODE_WRITE) begin
      if (rem_q == '0) begin
        if (item_i.entry_length == '0) begin
          cmd_o.op = OP_WR_ZERO;
        end else begin
          cmd_o.op   = OP_WR_START;
          cmd_o.last = (item_i.entry_length == 6'd1);
          rem_d      = item_i.entry_length - 6'd1;
        end
      end else begin
        cmd_o.op   = OP_WR_BYTE;
        cmd_o.last = (rem_q == 6'd1);
        rem_d      = rem_q - 6'd1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rem_q <= '0;
    end else if (accept) begin
      rem_q <= rem_d;
    end
  end

endmodule

// ===== rtl/lpbrq_back.sv =====
// Back part that owns the byte ring, its pointers and the write and read sequencing.
module lpbrq_back import lpbrq_pkg::*; #(
  parameter int BUFFER_BYTES = BUFFER_BYTES_DEF,
  parameter int MAX_ENTRY    = MAX_ENTRY_DEF
) (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  cmd_t    cmd_i,
  input  logic    cmd_empty_i,
  output logic    cmd_pop_o,
  input  logic    res_full_i,
  output logic    res_push_o,
  output result_t res_o
);

  localparam int AW  = $clog2(BUFFER_BYTES);
  localparam int AW1 = AW + 1;
  localparam logic [AW1-1:0] BufSize = AW1'(BUFFER_BYTES);

  function automatic logic [AW-1:0] ring_add(logic [AW-1:0] p, logic [AW1-1:0] n);
    logic [AW1-1:0] s;
    s = {1'b0, p} + n;
    if (s >= BufSize) begin
      s = s - BufSize;
    end
    return s[AW-1:0];
  endfunction

  logic [7:0]  ring_q [BUFFER_BYTES];
  logic [7:0]  rdata_q;

  back_state_e state_q, state_d;
  logic [AW-1:0] rp_q, rp_d;
  logic [AW-1:0] wp_q, wp_d;
  logic [AW-1:0] pwp_q, pwp_d;
  logic          rej_q, rej_d;
  cmd_t          cmd_q, cmd_d;
  logic [AW-1:0] pos_q, pos_d;
  logic [5:0]    cnt_q, cnt_d;
  logic [5:0]    idx_q, idx_d;
  status_e       stat_q, stat_d;

  logic          mem_we;
  logic [AW-1:0] waddr;
  logic [7:0]    wdata;
  logic [AW-1:0] raddr;

  logic [AW1-1:0] used;
  logic [AW1-1:0] freeb;
  logic           reject;
  logic [5:0]     len;
  logic [6:0]     lim;
  logic [5:0]     count;
  logic [AW-1:0]  pos_next;

  always_comb begin
    used   = (wp_q >= rp_q) ? AW1'(wp_q - rp_q) : AW1'({1'b0, wp_q} + BufSize - {1'b0, rp_q});
    freeb  = BufSize - used;
    reject = (32'(cmd_q.len) >= 32'(MAX_ENTRY)) ||
             (32'(freeb) <= 32'(HEADER_BYTES) + 32'(cmd_q.len));
    len    = rdata_q[5:0];
    lim    = (cmd_q.read_limit == '0) ? 7'd1 : cmd_q.read_limit;
    count  = ({1'b0, len} < lim) ? len : 6'(lim - 7'd1);
    pos_next = ring_add(pos_q, AW1'(1));
  end

  always_comb begin
    state_d    = state_q;
    rp_d       = rp_q;
    wp_d       = wp_q;
    pwp_d      = pwp_q;
    rej_d      = rej_q;
    cmd_d      = cmd_q;
    pos_d      = pos_q;
    cnt_d      = cnt_q;
    idx_d      = idx_q;
    stat_d     = stat_q;
    cmd_pop_o  = 1'b0;
    res_push_o = 1'b0;
    res_o      = '{out_byte: 8'd0, status: stat_q, read_count: 6'd0, last: 1'b1};
    mem_we     = 1'b0;
    waddr      = pwp_q;
    wdata      = cmd_q.data;
    raddr      = rp_q;

    case (state_q)
      S_IDLE: begin
        if (!cmd_empty_i) begin
          cmd_pop_o = 1'b1;
          cmd_d     = cmd_i;
          case (cmd_i.op)
            OP_WR_START: state_d = S_WHDR;
            OP_WR_BYTE:  state_d = S_WDATA;
            OP_WR_ZERO: begin
              stat_d  = ST_WRITE_REJECTED;
              state_d = S_PUSH;
            end
            OP_READ: begin
              if (rp_q == wp_q) begin
                stat_d  = ST_EMPTY;
                state_d = S_PUSH;
              end else begin
                state_d = S_RLEN;
              end
            end
            default: state_d = S_IDLE;
          endcase
        end
      end
      S_WHDR: begin
        rej_d = reject;
        if (!reject) begin
          mem_we = 1'b1;
          waddr  = wp_q;
          wdata  = 8'(cmd_q.len);
          pwp_d  = ring_add(wp_q, AW1'(HEADER_BYTES));
        end
        state_d = S_WDATA;
      end
      S_WDATA: begin
        if (!rej_q) begin
          mem_we = 1'b1;
          pwp_d  = ring_add(pwp_q, AW1'(1));
        end
        if (cmd_q.last) begin
          if (rej_q) begin
            rej_d  = 1'b0;
            stat_d = ST_WRITE_REJECTED;
          end else begin
            wp_d   = ring_add(pwp_q, AW1'(1));
            stat_d = ST_WRITE_ACCEPTED;
          end
          state_d = S_PUSH;
        end else begin
          state_d = S_IDLE;
        end
      end
      S_RLEN: begin
        rp_d  = ring_add(rp_q, AW1'(7'(HEADER_BYTES) + {1'b0, len}));
        pos_d = ring_add(rp_q, AW1'(HEADER_BYTES));
        raddr = ring_add(rp_q, AW1'(HEADER_BYTES));
        cnt_d = count;
        idx_d = '0;
        if (count == '0) begin
          stat_d  = ST_SKIPPED;
          state_d = S_PUSH;
        end else begin
          state_d = S_RDATA;
        end
      end
      S_RDATA: begin
        res_o = '{out_byte: rdata_q, status: ST_READ_BYTE, read_count: cnt_q,
                  last: (idx_q + 6'd1 == cnt_q)};
        raddr = pos_q;
        if (!res_full_i) begin
          res_push_o = 1'b1;
          raddr      = pos_next;
          pos_d      = pos_next;
          idx_d      = idx_q + 6'd1;
          if (idx_q + 6'd1 == cnt_q) begin
            state_d = S_IDLE;
          end
        end
      end
      S_PUSH: begin
        if (!res_full_i) begin
          res_push_o = 1'b1;
          state_d    = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      rp_q    <= '0;
      wp_q    <= '0;
      pwp_q   <= '0;
      rej_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      rp_q    <= rp_d;
      wp_q    <= wp_d;
      pwp_q   <= pwp_d;
      rej_q   <= rej_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q  <= cmd_d;
    pos_q  <= pos_d;
    cnt_q  <= cnt_d;
    idx_q  <= idx_d;
    stat_q <= stat_d;
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      ring_q[waddr] <= wdata;
    end
    rdata_q <= ring_q[raddr];
  end

endmodule

// ===== rtl/length_prefixed_byte_ring_queue_top.sv =====
// Top level of the length-prefixed byte ring queue.
//
//   Side     Handshake        Payload
//   input    push / full      item_i   (mode, entry_length, in_byte, read_limit)
//   result   pop / empty      result_o (out_byte, status, read_count, last)
//
// A write byte passes the idle and data states of the back part, the first byte of an entry
// also the header state, and the last byte also the push state for its status result.
// A read fetches the length header in the read-length state and then returns its bytes
// while the result queue has room, bounded by the single port of the byte ring.
// Reset clears the pointers and both queues; the ring contents are not cleared.
// A full result queue stalls the back part, and a full command queue raises full.
module length_prefixed_byte_ring_queue_top import lpbrq_pkg::*; #(
  parameter int BUFFER_BYTES = BUFFER_BYTES_DEF,
  parameter int MAX_ENTRY    = MAX_ENTRY_DEF
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     push,
  output logic     full,
  input  in_item_t item_i,
  output logic     empty,
  input  logic     pop,
  output result_t  result_o
);

  cmd_t    front_cmd;
  logic    front_push;
  cmd_t    cmd_head;
  logic    cmd_empty;
  logic    cmd_pop;
  logic    res_full;
  logic    res_push;
  result_t back_res;

  lpbrq_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .item_push_i (push),
    .item_i      (item_i),
    .cmd_full_i  (full),
    .cmd_push_o  (front_push),
    .cmd_o       (front_cmd)
  );

  lpbrq_fifo #(
    .Width ($bits(cmd_t)),
    .Depth (CMD_QUEUE_DEPTH)
  ) u_cmd_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (front_push),
    .wdata_i (front_cmd),
    .pop_i   (cmd_pop),
    .rdata_o (cmd_head),
    .full_o  (full),
    .empty_o (cmd_empty)
  );

  lpbrq_back #(
    .BUFFER_BYTES (BUFFER_BYTES),
    .MAX_ENTRY    (MAX_ENTRY)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd_head),
    .cmd_empty_i (cmd_empty),
    .cmd_pop_o   (cmd_pop),
    .res_full_i  (res_full),
    .res_push_o  (res_push),
    .res_o       (back_res)
  );

  lpbrq_fifo #(
    .Width ($bits(result_t)),
    .Depth (RES_QUEUE_DEPTH)
  ) u_res_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (res_push),
    .wdata_i (back_res),
    .pop_i   (pop),
    .rdata_o (result_o),
    .full_o  (res_full),
    .empty_o (empty)
  );

`ifndef SYNTHESIS
  a_byte_has_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && result_o.status == ST_READ_BYTE) |-> (result_o.read_count != 6'd0))
    else $error("A read byte result carries a zero count.");

  a_status_is_final: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && result_o.status != ST_READ_BYTE) |->
    (result_o.last && result_o.out_byte == 8'd0 && result_o.read_count == 6'd0))
    else $error("A status result is not a lone final item.");

  a_result_fits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && result_o.status == ST_READ_BYTE && result_o.read_count != 6'd0) |->
    (result_o.status != ST_EMPTY))
    else $error("A read byte result is mislabeled.");
`endif

endmodule
